/* src/cado_pkg.sv */
// Shared types and constants for the Chaikin A/D oscillator.
package cado_pkg;

  localparam int MAX_PERIOD_DEF    = 1024;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int PERIOD_W  = 11;
  localparam int GAIN_W    = 31;
  localparam int PRICE_W   = 32;
  localparam int VALUE_W   = 64;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 31;

  // Register indexes of the config port.
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PERIOD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_GAIN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_GAIN    = 2'd3;

  // Divider geometry: 64-bit dividend, 32-bit divisor, 7-bit step count.
  localparam int DVD_W      = 64;
  localparam int DVS_W      = 32;
  localparam int DIV_STEP_W = 7;

  typedef struct packed {
    logic                  start;
    logic [DIV_STEP_W-1:0] steps;
  } div_ctl_t;

endpackage

/* src/cado_div.sv */
// Shared restoring divider, one quotient bit per cycle.
module cado_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cado_pkg::div_ctl_t          ctl,
  input  logic [cado_pkg::DVD_W-1:0]  dividend,
  input  logic [cado_pkg::DVS_W-1:0]  divisor,
  output logic                        done,
  output logic [cado_pkg::DVD_W-1:0]  quotient
);

  logic                            busy_r;
  logic                            done_r;
  logic [cado_pkg::DIV_STEP_W-1:0] cnt_r;
  logic [cado_pkg::DVS_W-1:0]      rem_r;
  logic [cado_pkg::DVD_W-1:0]      quo_r;
  logic [cado_pkg::DVS_W-1:0]      dvs_r;

  logic [cado_pkg::DVS_W:0]        sh;
  logic [cado_pkg::DVS_W:0]        sub;
  logic                            fits;

  // Shift in the next dividend bit, subtract when the divisor fits.
  assign sh   = {rem_r, quo_r[cado_pkg::DVD_W-1]};
  assign fits = (sh >= {1'b0, dvs_r});
  assign sub  = sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= ctl.steps;
        rem_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= fits ? sub[cado_pkg::DVS_W-1:0] : sh[cado_pkg::DVS_W-1:0];
        quo_r <= {quo_r[cado_pkg::DVD_W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == cado_pkg::DIV_STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !busy_r)
    else $error("divider restarted while busy");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r < dvs_r))
    else $error("partial remainder not below divisor");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> $past(busy_r))
    else $error("divider done without a running division");

endmodule

/* src/chaikin_ad_oscillator.sv */
// Top level of the Chaikin accumulation/distribution oscillator.
//
// Input channel: one price bar per beat (high, low, close, volume, and a
// start_series flag that clears the line, averages, seed sums and bar count
// before the bar). Result channel: one beat per bar carrying the A/D line,
// the oscillator (short minus long average), its valid flag and a flag for a
// bar whose high equals its low. Both channels use valid/stall; a beat moves
// when valid is high and stall is low.
// Config port: cfg_we with cfg_index (0 short period, 1 long period, 2 short
// gain, 3 long gain) and cfg_data. The user must see that it is written only
// while the block is idle; the block itself does not enforce this.
// One bar at a time; the bit-serial divider for the money flow multiplier
// sets the pace, and a flat bar skips it. A seeding average adds the line to
// its seed sum, a tracking one runs the gain step, and the bar that completes
// a seed runs the divider for the seed mean. One 32x32 multiplier and one
// 64-bit saturating adder serve all multiply and add steps. in_stall is high
// from acceptance until the sequencer returns to idle. The result sits in an
// output register; a new bar is accepted while it waits, and only the next
// result holds off.
// Reset (synchronous, rst_n low) clears series state and restores the defaults.
module chaikin_ad_oscillator #(
  parameter int MAX_PERIOD    = cado_pkg::MAX_PERIOD_DEF,
  parameter int FRACTION_BITS = cado_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // bar input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_start_series,
  input  logic [cado_pkg::PRICE_W-1:0]        in_high_price,
  input  logic [cado_pkg::PRICE_W-1:0]        in_low_price,
  input  logic [cado_pkg::PRICE_W-1:0]        in_close_price,
  input  logic [cado_pkg::PRICE_W-1:0]        in_bar_volume,
  // result output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [cado_pkg::VALUE_W-1:0] out_ad_line,
  output logic signed [cado_pkg::VALUE_W-1:0] out_osc_value,
  output logic                                out_osc_valid,
  output logic                                out_zero_range_error,
  // configuration
  input  logic                                cfg_we,
  input  logic [cado_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cado_pkg::CFG_DAT_W-1:0]      cfg_data
);

  localparam int BS_W = $clog2(MAX_PERIOD + 2);
  localparam logic [BS_W-1:0] BS_SAT = BS_W'(MAX_PERIOD + 1);
  localparam int W = cado_pkg::VALUE_W;

  localparam logic [W-1:0] S_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] S_MIN = {1'b1, {(W-1){1'b0}}};

  localparam logic [cado_pkg::PERIOD_W-1:0] SHORT_PERIOD_RST = 11'd3;
  localparam logic [cado_pkg::PERIOD_W-1:0] LONG_PERIOD_RST  = 11'd10;
  localparam logic [cado_pkg::GAIN_W-1:0]   SHORT_GAIN_RST   = 31'd536870912;
  localparam logic [cado_pkg::GAIN_W-1:0]   LONG_GAIN_RST    = 31'd195225786;

  // Sequencer states
  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_PREP      = 5'd1;
  localparam logic [4:0] S_LOAD      = 5'd2;
  localparam logic [4:0] S_DIV_WAIT  = 5'd3;
  localparam logic [4:0] S_MUL_LO    = 5'd4;
  localparam logic [4:0] S_MUL_HI    = 5'd5;
  localparam logic [4:0] S_FLOW      = 5'd6;
  localparam logic [4:0] S_ACC       = 5'd7;
  localparam logic [4:0] S_AVG       = 5'd8;
  localparam logic [4:0] S_SEED_LOAD = 5'd9;
  localparam logic [4:0] S_SEED_WAIT = 5'd10;
  localparam logic [4:0] S_DIFF      = 5'd11;
  localparam logic [4:0] S_GMAG      = 5'd12;
  localparam logic [4:0] S_G_LO      = 5'd13;
  localparam logic [4:0] S_G_HI      = 5'd14;
  localparam logic [4:0] S_G_STEP    = 5'd15;
  localparam logic [4:0] S_G_ADD     = 5'd16;
  localparam logic [4:0] S_NEXT      = 5'd17;
  localparam logic [4:0] S_OSC       = 5'd18;

  // Configuration registers
  logic [cado_pkg::PERIOD_W-1:0] short_period_r, long_period_r;
  logic [cado_pkg::GAIN_W-1:0]   short_gain_r, long_gain_r;

  // Control state
  logic [4:0]      state_r, state_nxt;
  logic            sel_r, sel_nxt;          // 0 short average, 1 long average
  logic [BS_W-1:0] bs_r, bs_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Bar payload and working registers
  logic [cado_pkg::PRICE_W-1:0] high_r, high_nxt, low_r, low_nxt;
  logic [cado_pkg::PRICE_W-1:0] close_r, close_nxt, vol_r, vol_nxt;
  logic [34:0]  num_r, num_nxt;             // 2c-l-h, signed
  logic [32:0]  den_r, den_nxt;             // h-l, signed
  logic         err_r, err_nxt;
  logic         neg_r, neg_nxt;
  logic [W-1:0] mag_r, mag_nxt;
  logic [W-1:0] pl_r, pl_nxt, ph_r, ph_nxt;
  logic [W-1:0] flow_r, flow_nxt, diff_r, diff_nxt, step_r, step_nxt;

  // Series state
  logic [W-1:0] ad_r, ad_nxt;
  logic [W-1:0] sh_avg_r, sh_avg_nxt, lg_avg_r, lg_avg_nxt;
  logic [W-1:0] sh_seed_r, sh_seed_nxt, lg_seed_r, lg_seed_nxt;

  // Output registers
  logic [W-1:0] o_ad_r, o_ad_nxt, o_osc_r, o_osc_nxt;
  logic         o_oscv_r, o_oscv_nxt, o_err_r, o_err_nxt;

  // Effective periods and per-average selections
  logic [BS_W-1:0]             sp_eff, lp_eff, cur_p;
  logic [W-1:0]                cur_avg, cur_seed;
  logic [cado_pkg::GAIN_W-1:0] cur_g;

  // Shared units
  logic [W-1:0]  add_a, add_b, add_res;
  logic          add_sub;
  logic [W:0]    add_bx, add_sum;
  logic [31:0]   mul_a, mul_b;
  logic [W-1:0]  mul_p;

  cado_pkg::div_ctl_t          div_ctl;
  logic [cado_pkg::DVD_W-1:0]  div_dvd, div_quo;
  logic [cado_pkg::DVS_W-1:0]  div_dvs;
  logic                        div_done;

  // Scratch for combinational steps
  logic [34:0]  num_mag;
  logic [32:0]  den_mag;
  logic [W:0]   flow_sum;
  logic         flow_over;
  logic [W-1:0] flow_p;
  logic [W:0]   step_sum;
  logic         step_over;

  cado_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Clamp periods: zero acts as one, above the maximum acts as the maximum.
  always_comb begin
    if (short_period_r == '0) begin
      sp_eff = BS_W'(1);
    end else if (int'(short_period_r) > MAX_PERIOD) begin
      sp_eff = BS_W'(MAX_PERIOD);
    end else begin
      sp_eff = BS_W'(short_period_r);
    end
    if (long_period_r == '0) begin
      lp_eff = BS_W'(1);
    end else if (int'(long_period_r) > MAX_PERIOD) begin
      lp_eff = BS_W'(MAX_PERIOD);
    end else begin
      lp_eff = BS_W'(long_period_r);
    end
  end

  assign cur_p    = sel_r ? lp_eff    : sp_eff;
  assign cur_avg  = sel_r ? lg_avg_r  : sh_avg_r;
  assign cur_seed = sel_r ? lg_seed_r : sh_seed_r;
  assign cur_g    = sel_r ? long_gain_r : short_gain_r;

  // Shared 64-bit saturating adder/subtractor; operands picked by state.
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (state_r)
      S_ACC: begin
        add_a = ad_r;
        add_b = flow_r;
      end
      S_AVG: begin
        add_a = cur_seed;
        add_b = ad_r;
      end
      S_DIFF: begin
        add_a   = ad_r;
        add_b   = cur_avg;
        add_sub = 1'b1;
      end
      S_G_ADD: begin
        add_a = cur_avg;
        add_b = step_r;
      end
      S_OSC: begin
        add_a   = sh_avg_r;
        add_b   = lg_avg_r;
        add_sub = 1'b1;
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  assign add_bx  = add_sub ? ~{add_b[W-1], add_b} : {add_b[W-1], add_b};
  assign add_sum = {add_a[W-1], add_a} + add_bx + (W+1)'(add_sub);
  assign add_res = (add_sum[W] != add_sum[W-1]) ? (add_sum[W] ? S_MIN : S_MAX)
                                                : add_sum[W-1:0];

  // Shared 32x32 multiplier; product is registered into pl_r or ph_r.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MUL_LO: begin
        mul_a = mag_r[31:0];
        mul_b = vol_r;
      end
      S_MUL_HI: begin
        mul_a = mag_r[63:32];
        mul_b = vol_r;
      end
      S_G_LO: begin
        mul_a = mag_r[31:0];
        mul_b = {1'b0, cur_g};
      end
      S_G_HI: begin
        mul_a = mag_r[63:32];
        mul_b = {1'b0, cur_g};
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

  // Flow magnitude mag*vol = (ph << 32) + pl; saturate beyond the signed range.
  assign flow_sum  = {2'b0, ph_r[30:0], 32'b0} + {1'b0, pl_r};
  assign flow_over = (|ph_r[63:31]) | flow_sum[W] | flow_sum[W-1];
  assign flow_p    = {1'b0, flow_sum[W-2:0]};

  // Gain step: (ph << 2) + (pl >> 30), magnitude truncated.
  assign step_sum  = {1'b0, ph_r[61:0], 2'b0} + {31'b0, pl_r[63:30]};
  assign step_over = (ph_r > (W'(1) << 61)) | step_sum[W] | step_sum[W-1];

  assign num_mag = num_r[34] ? (35'd0 - num_r) : num_r;
  assign den_mag = den_r[32] ? (33'd0 - den_r) : den_r;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    bs_nxt        = bs_r;
    out_valid_nxt = out_valid_r;
    high_nxt      = high_r;
    low_nxt       = low_r;
    close_nxt     = close_r;
    vol_nxt       = vol_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    err_nxt       = err_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    pl_nxt        = pl_r;
    ph_nxt        = ph_r;
    flow_nxt      = flow_r;
    diff_nxt      = diff_r;
    step_nxt      = step_r;
    ad_nxt        = ad_r;
    sh_avg_nxt    = sh_avg_r;
    lg_avg_nxt    = lg_avg_r;
    sh_seed_nxt   = sh_seed_r;
    lg_seed_nxt   = lg_seed_r;
    o_ad_nxt      = o_ad_r;
    o_osc_nxt     = o_osc_r;
    o_oscv_nxt    = o_oscv_r;
    o_err_nxt     = o_err_r;
    div_ctl       = '0;
    div_dvd       = '0;
    div_dvs       = '0;

    // Drop the result once the receiver takes it.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          high_nxt  = in_high_price;
          low_nxt   = in_low_price;
          close_nxt = in_close_price;
          vol_nxt   = in_bar_volume;
          if (in_start_series) begin
            ad_nxt      = '0;
            sh_avg_nxt  = '0;
            lg_avg_nxt  = '0;
            sh_seed_nxt = '0;
            lg_seed_nxt = '0;
            bs_nxt      = '0;
          end
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        num_nxt = {2'b0, close_r, 1'b0} - {3'b0, low_r} - {3'b0, high_r};
        den_nxt = {1'b0, high_r} - {1'b0, low_r};
        err_nxt = (high_r == low_r);
        if (high_r == low_r) begin
          mag_nxt   = '0;
          neg_nxt   = 1'b0;
          state_nxt = S_MUL_LO;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        // |num| << FRACTION_BITS, aligned to the top of the dividend.
        div_ctl.start = 1'b1;
        div_ctl.steps = cado_pkg::DIV_STEP_W'(33 + FRACTION_BITS);
        div_dvd       = {num_mag[32:0], 31'b0};
        div_dvs       = den_mag[31:0];
        neg_nxt       = num_r[34] ^ den_r[32];
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          mag_nxt   = div_quo;
          state_nxt = S_MUL_LO;
        end
      end
      S_MUL_LO: begin
        pl_nxt    = mul_p;
        state_nxt = S_MUL_HI;
      end
      S_MUL_HI: begin
        ph_nxt    = mul_p;
        state_nxt = S_FLOW;
      end
      S_FLOW: begin
        if (flow_over) begin
          flow_nxt = neg_r ? S_MIN : S_MAX;
        end else begin
          flow_nxt = neg_r ? (W'(0) - flow_p) : flow_p;
        end
        state_nxt = S_ACC;
      end
      S_ACC: begin
        ad_nxt = add_res;
        if (bs_r != BS_SAT) begin
          bs_nxt = bs_r + 1'b1;
        end
        sel_nxt   = 1'b0;
        state_nxt = S_AVG;
      end
      S_AVG: begin
        if (bs_r <= cur_p) begin
          // Still seeding: accumulate the line value.
          if (sel_r) begin
            lg_seed_nxt = add_res;
          end else begin
            sh_seed_nxt = add_res;
          end
          state_nxt = (bs_r == cur_p) ? S_SEED_LOAD : S_NEXT;
        end else begin
          state_nxt = S_DIFF;
        end
      end
      S_SEED_LOAD: begin
        div_ctl.start = 1'b1;
        div_ctl.steps = cado_pkg::DIV_STEP_W'(cado_pkg::DVD_W);
        div_dvd       = cur_seed[W-1] ? (W'(0) - cur_seed) : cur_seed;
        div_dvs       = cado_pkg::DVS_W'(cur_p);
        neg_nxt       = cur_seed[W-1];
        state_nxt     = S_SEED_WAIT;
      end
      S_SEED_WAIT: begin
        if (div_done) begin
          if (sel_r) begin
            lg_avg_nxt = neg_r ? (W'(0) - div_quo) : div_quo;
          end else begin
            sh_avg_nxt = neg_r ? (W'(0) - div_quo) : div_quo;
          end
          state_nxt = S_NEXT;
        end
      end
      S_DIFF: begin
        diff_nxt  = add_res;
        state_nxt = S_GMAG;
      end
      S_GMAG: begin
        neg_nxt   = diff_r[W-1];
        mag_nxt   = diff_r[W-1] ? (W'(0) - diff_r) : diff_r;
        state_nxt = S_G_LO;
      end
      S_G_LO: begin
        pl_nxt    = mul_p;
        state_nxt = S_G_HI;
      end
      S_G_HI: begin
        ph_nxt    = mul_p;
        state_nxt = S_G_STEP;
      end
      S_G_STEP: begin
        if (step_over) begin
          step_nxt = neg_r ? S_MIN : S_MAX;
        end else begin
          step_nxt = neg_r ? (W'(0) - step_sum[W-1:0]) : step_sum[W-1:0];
        end
        state_nxt = S_G_ADD;
      end
      S_G_ADD: begin
        if (sel_r) begin
          lg_avg_nxt = add_res;
        end else begin
          sh_avg_nxt = add_res;
        end
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        if (!sel_r) begin
          sel_nxt   = 1'b1;
          state_nxt = S_AVG;
        end else begin
          state_nxt = S_OSC;
        end
      end
      S_OSC: begin
        // Hold until the output register is free.
        if (!out_valid_r || !out_stall) begin
          o_ad_nxt      = ad_r;
          o_oscv_nxt    = (bs_r > lp_eff);
          o_osc_nxt     = (bs_r > lp_eff) ? add_res : '0;
          o_err_nxt     = err_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      sel_r          <= 1'b0;
      bs_r           <= '0;
      out_valid_r    <= 1'b0;
      ad_r           <= '0;
      sh_avg_r       <= '0;
      lg_avg_r       <= '0;
      sh_seed_r      <= '0;
      lg_seed_r      <= '0;
      short_period_r <= SHORT_PERIOD_RST;
      long_period_r  <= LONG_PERIOD_RST;
      short_gain_r   <= SHORT_GAIN_RST;
      long_gain_r    <= LONG_GAIN_RST;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      bs_r        <= bs_nxt;
      out_valid_r <= out_valid_nxt;
      ad_r        <= ad_nxt;
      sh_avg_r    <= sh_avg_nxt;
      lg_avg_r    <= lg_avg_nxt;
      sh_seed_r   <= sh_seed_nxt;
      lg_seed_r   <= lg_seed_nxt;
      if (cfg_we) begin
        case (cfg_index)
          cado_pkg::CFG_SHORT_PERIOD: short_period_r <= cfg_data[cado_pkg::PERIOD_W-1:0];
          cado_pkg::CFG_LONG_PERIOD:  long_period_r  <= cfg_data[cado_pkg::PERIOD_W-1:0];
          cado_pkg::CFG_SHORT_GAIN:   short_gain_r   <= cfg_data[cado_pkg::GAIN_W-1:0];
          cado_pkg::CFG_LONG_GAIN:    long_gain_r    <= cfg_data[cado_pkg::GAIN_W-1:0];
          default:                    short_gain_r   <= short_gain_r;
        endcase
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    high_r   <= high_nxt;
    low_r    <= low_nxt;
    close_r  <= close_nxt;
    vol_r    <= vol_nxt;
    num_r    <= num_nxt;
    den_r    <= den_nxt;
    err_r    <= err_nxt;
    neg_r    <= neg_nxt;
    mag_r    <= mag_nxt;
    pl_r     <= pl_nxt;
    ph_r     <= ph_nxt;
    flow_r   <= flow_nxt;
    diff_r   <= diff_nxt;
    step_r   <= step_nxt;
    o_ad_r   <= o_ad_nxt;
    o_osc_r  <= o_osc_nxt;
    o_oscv_r <= o_oscv_nxt;
    o_err_r  <= o_err_nxt;
  end

  assign in_stall             = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_ad_line          = o_ad_r;
  assign out_osc_value        = o_osc_r;
  assign out_osc_valid        = o_oscv_r;
  assign out_zero_range_error = o_err_r;

  a_osc_zero_until_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_osc_valid || out_osc_value == '0))
    else $error("oscillator nonzero before it is valid");

  a_bar_count_capped: assert property (@(posedge clk) disable iff (!rst_n)
    bs_r <= BS_SAT)
    else $error("bar count beyond its cap");

  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV_WAIT || state_r == S_SEED_WAIT))
    else $error("divider finished outside a wait state");

endmodule

/* test/chaikin_ad_oscillator_tb.sv */
// Self-checking testbench for the Chaikin A/D oscillator: predicted results per bar.
module chaikin_ad_oscillator_tb;

  localparam logic signed [cado_pkg::VALUE_W-1:0] VAL_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [cado_pkg::VALUE_W-1:0] VAL_MIN  = 64'sh8000_0000_0000_0000;
  localparam logic [127:0]                        WIDE_MAX = 128'h7FFF_FFFF_FFFF_FFFF;

  localparam int BAR_COUNT_CAP  = cado_pkg::MAX_PERIOD_DEF + 1;
  localparam int RANDOM_PHASES  = 8;
  localparam int BARS_PER_PHASE = 66;
  localparam int LONG_HOLD      = 1000;  // receiver hold-off in the pressure phase
  localparam int SETTLE_CYCLES  = 300;   // settling time after the final drain
  localparam int WATCHDOG_LIMIT = 6000;  // cycles without any accepted beat or config write

  typedef struct packed {
    logic                         start_series;
    logic [cado_pkg::PRICE_W-1:0] high_price;
    logic [cado_pkg::PRICE_W-1:0] low_price;
    logic [cado_pkg::PRICE_W-1:0] close_price;
    logic [cado_pkg::PRICE_W-1:0] bar_volume;
  } price_bar_t;

  typedef struct {
    logic signed [cado_pkg::VALUE_W-1:0] ad_line;
    logic signed [cado_pkg::VALUE_W-1:0] osc_value;
    logic                                osc_valid;
    logic                                zero_range_error;
  } osc_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                                in_valid        = 1'b0;
  logic                                in_stall;
  logic                                in_start_series = 1'b0;
  logic [cado_pkg::PRICE_W-1:0]        in_high_price   = '0;
  logic [cado_pkg::PRICE_W-1:0]        in_low_price    = '0;
  logic [cado_pkg::PRICE_W-1:0]        in_close_price  = '0;
  logic [cado_pkg::PRICE_W-1:0]        in_bar_volume   = '0;
  logic                                out_valid;
  logic                                out_stall       = 1'b0;
  logic signed [cado_pkg::VALUE_W-1:0] out_ad_line;
  logic signed [cado_pkg::VALUE_W-1:0] out_osc_value;
  logic                                out_osc_valid;
  logic                                out_zero_range_error;
  logic                                cfg_we          = 1'b0;
  logic [cado_pkg::CFG_IDX_W-1:0]      cfg_index       = '0;
  logic [cado_pkg::CFG_DAT_W-1:0]      cfg_data        = '0;

  // Bars waiting to be driven, and results the block still owes us.
  price_bar_t  bar_queue[$];
  osc_result_t due_results[$];
  price_bar_t  next_bar;
  osc_result_t got_due;

  // Mirror of the config registers, reset values included.
  logic [cado_pkg::PERIOD_W-1:0] short_period_reg = 11'd3;
  logic [cado_pkg::PERIOD_W-1:0] long_period_reg  = 11'd10;
  logic [cado_pkg::GAIN_W-1:0]   short_gain_reg   = 31'd536870912;
  logic [cado_pkg::GAIN_W-1:0]   long_gain_reg    = 31'd195225786;

  // Series state of the predictor; index 0 is the short average, 1 the long one.
  logic signed [cado_pkg::VALUE_W-1:0] ad_sum = '0;
  logic signed [cado_pkg::VALUE_W-1:0] avg_val[2];
  logic signed [cado_pkg::VALUE_W-1:0] seed_sum[2];
  int                                  bar_count = 0;

  // Traffic shaping, set per phase by the stimulus.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  logic        hold_req      = 1'b0;
  logic        hold_seen     = 1'b0;
  int          hold_left     = 0;

  int error_count = 0;
  int quiet_cycles = 0;

  chaikin_ad_oscillator i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_start_series     (in_start_series),
    .in_high_price       (in_high_price),
    .in_low_price        (in_low_price),
    .in_close_price      (in_close_price),
    .in_bar_volume       (in_bar_volume),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_ad_line         (out_ad_line),
    .out_osc_value       (out_osc_value),
    .out_osc_valid       (out_osc_valid),
    .out_zero_range_error(out_zero_range_error),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic signed [cado_pkg::VALUE_W-1:0] sat_sum(
      logic signed [cado_pkg::VALUE_W-1:0] a, logic signed [cado_pkg::VALUE_W-1:0] b);
    logic signed [cado_pkg::VALUE_W:0] s;
    s = a + b;
    if (s > VAL_MAX) return VAL_MAX;
    if (s < VAL_MIN) return VAL_MIN;
    return s[cado_pkg::VALUE_W-1:0];
  endfunction

  function automatic logic signed [cado_pkg::VALUE_W-1:0] sat_diff(
      logic signed [cado_pkg::VALUE_W-1:0] a, logic signed [cado_pkg::VALUE_W-1:0] b);
    logic signed [cado_pkg::VALUE_W:0] s;
    s = a - b;
    if (s > VAL_MAX) return VAL_MAX;
    if (s < VAL_MIN) return VAL_MIN;
    return s[cado_pkg::VALUE_W-1:0];
  endfunction

  // Q1.30 gain times a signed value; the magnitude is truncated, so the step
  // rounds toward zero, then saturates.
  function automatic logic signed [cado_pkg::VALUE_W-1:0] gain_scale(
      logic signed [cado_pkg::VALUE_W-1:0] diff, logic [cado_pkg::GAIN_W-1:0] g);
    logic [cado_pkg::VALUE_W-1:0] mag;
    logic [127:0]                 prod;
    mag  = diff[cado_pkg::VALUE_W-1] ? ~diff + 64'd1 : diff;
    prod = ({64'd0, mag} * {97'd0, g}) >> 30;
    if (diff[cado_pkg::VALUE_W-1])
      return (prod > WIDE_MAX) ? VAL_MIN : -$signed(prod[cado_pkg::VALUE_W-1:0]);
    return (prod > WIDE_MAX) ? VAL_MAX : $signed(prod[cado_pkg::VALUE_W-1:0]);
  endfunction

  // A period of 0 acts as 1, anything above the maximum as the maximum.
  function automatic int period_used(logic [cado_pkg::PERIOD_W-1:0] p);
    if (p == 0) return 1;
    if (p > cado_pkg::MAX_PERIOD_DEF) return cado_pkg::MAX_PERIOD_DEF;
    return int'(p);
  endfunction

  // Advance the series by one bar and queue the result it must produce.
  function automatic void compute_oscillator(price_bar_t b);
    logic signed [cado_pkg::VALUE_W-1:0] hs, ls, cs, num, mult, flow;
    logic [cado_pkg::VALUE_W-1:0]        mag;
    logic [127:0]                        prod;
    int                                  per[2];
    logic [cado_pkg::GAIN_W-1:0]         gain[2];
    osc_result_t                         res;
    per[0]  = period_used(short_period_reg);
    per[1]  = period_used(long_period_reg);
    gain[0] = short_gain_reg;
    gain[1] = long_gain_reg;
    if (b.start_series) begin
      ad_sum    = '0;
      avg_val   = '{default: '0};
      seed_sum  = '{default: '0};
      bar_count = 0;
    end
    hs = {32'd0, b.high_price};
    ls = {32'd0, b.low_price};
    cs = {32'd0, b.close_price};
    res.zero_range_error = (b.high_price == b.low_price);
    flow = '0;
    if (!res.zero_range_error) begin
      // Money flow multiplier, truncated toward zero; inverted bars go as is.
      num  = 2 * cs - ls - hs;
      mult = (num * (64'sd1 <<< cado_pkg::FRACTION_BITS_DEF)) / (hs - ls);
      mag  = mult[cado_pkg::VALUE_W-1] ? ~mult + 64'd1 : mult;
      prod = {64'd0, mag} * {96'd0, b.bar_volume};
      if (mult[cado_pkg::VALUE_W-1])
        flow = (prod > WIDE_MAX) ? VAL_MIN : -$signed(prod[cado_pkg::VALUE_W-1:0]);
      else
        flow = (prod > WIDE_MAX) ? VAL_MAX : $signed(prod[cado_pkg::VALUE_W-1:0]);
    end
    ad_sum = sat_sum(ad_sum, flow);
    if (bar_count < BAR_COUNT_CAP) bar_count++;
    // Seed with the mean of the first period values, then track by gain.
    for (int k = 0; k < 2; k++) begin
      if (bar_count < per[k]) begin
        seed_sum[k] = sat_sum(seed_sum[k], ad_sum);
      end else if (bar_count == per[k]) begin
        seed_sum[k] = sat_sum(seed_sum[k], ad_sum);
        avg_val[k]  = seed_sum[k] / longint'(per[k]);
      end else begin
        avg_val[k] = sat_sum(avg_val[k],
                             gain_scale(sat_diff(ad_sum, avg_val[k]), gain[k]));
      end
    end
    res.ad_line   = ad_sum;
    res.osc_valid = (bar_count > per[1]);
    res.osc_value = res.osc_valid ? sat_diff(avg_val[0], avg_val[1]) : '0;
    due_results.insert(due_results.size(), res);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: feed bars from bar_queue, predict each bar at acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        compute_oscillator({in_start_series, in_high_price, in_low_price,
                            in_close_price, in_bar_volume});
      // Hold a stalled beat; otherwise advance to the next bar or go idle.
      if (!in_valid || !in_stall) begin
        if (bar_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_bar        = bar_queue.pop_front();
          in_valid        <= 1'b1;
          in_start_series <= next_bar.start_series;
          in_high_price   <= next_bar.high_price;
          in_low_price    <= next_bar.low_price;
          in_close_price  <= next_bar.close_price;
          in_bar_volume   <= next_bar.bar_volume;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall, plus a long hold-off when the stimulus asks
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result beat with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $display("%0t: result beat with nothing expected: expected none, got ad_line %0d",
                 $time, out_ad_line);
        error_count++;
      end else begin
        got_due = due_results.pop_front();
        if (out_ad_line !== got_due.ad_line) begin
          $display("%0t: ad_line expected %0d, got %0d", $time, got_due.ad_line, out_ad_line);
          error_count++;
        end
        if (out_osc_value !== got_due.osc_value) begin
          $display("%0t: osc_value expected %0d, got %0d",
                   $time, got_due.osc_value, out_osc_value);
          error_count++;
        end
        if (out_osc_valid !== got_due.osc_valid) begin
          $display("%0t: osc_valid expected %0b, got %0b",
                   $time, got_due.osc_valid, out_osc_valid);
          error_count++;
        end
        if (out_zero_range_error !== got_due.zero_range_error) begin
          $display("%0t: zero_range_error expected %0b, got %0b",
                   $time, got_due.zero_range_error, out_zero_range_error);
          error_count++;
        end
      end
    end
  end

  // Watchdog: drop the run when nothing has moved for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
        $display("chaikin_ad_oscillator_tb: done, errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mix of full-range, near-zero, near-top and mid-size values.
  function automatic logic [cado_pkg::PRICE_W-1:0] pick_value();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $urandom_range(0, 2000);
      2:       return 32'hFFFF_FFFF - $urandom_range(0, 2000);
      default: return $urandom_range(0, 1 << 20);
    endcase
  endfunction

  // Mostly well-formed bars (low <= close <= high) with random content; the
  // rest are flat bars and noise with inverted or out-of-range prices.
  function automatic price_bar_t draw_bar();
    price_bar_t                   b;
    int unsigned                  kind;
    logic [cado_pkg::PRICE_W-1:0] x, y;
    kind           = $urandom_range(99);
    b.start_series = ($urandom_range(39) == 0);
    b.bar_volume   = ($urandom_range(15) == 0) ? '0 : pick_value();
    if (kind < 80) begin
      x = pick_value();
      y = x + (($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 5000));
      b.high_price  = (x > y) ? x : y;
      b.low_price   = (x > y) ? y : x;
      b.close_price = b.low_price + $urandom_range(0, b.high_price - b.low_price);
    end else if (kind < 90) begin
      b.high_price  = pick_value();
      b.low_price   = b.high_price;
      b.close_price = pick_value();
    end else begin
      b.high_price  = pick_value();
      b.low_price   = pick_value();
      b.close_price = pick_value();
    end
    return b;
  endfunction

  // Write all four registers on consecutive cycles; upper data bits of the
  // period writes carry junk that the block must drop.
  task automatic program_regs(input logic [cado_pkg::PERIOD_W-1:0] sp,
                              input logic [cado_pkg::PERIOD_W-1:0] lp,
                              input logic [cado_pkg::GAIN_W-1:0]   sg,
                              input logic [cado_pkg::GAIN_W-1:0]   lg);
    logic [cado_pkg::CFG_IDX_W-1:0] idx_list[4];
    logic [cado_pkg::CFG_DAT_W-1:0] word[4];
    idx_list = '{cado_pkg::CFG_SHORT_PERIOD, cado_pkg::CFG_LONG_PERIOD,
                 cado_pkg::CFG_SHORT_GAIN, cado_pkg::CFG_LONG_GAIN};
    word     = '{{20'($urandom), sp}, {20'($urandom), lp}, sg, lg};
    for (int k = 0; k < 4; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx_list[k];
      cfg_data  <= word[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    short_period_reg = word[0][cado_pkg::PERIOD_W-1:0];
    long_period_reg  = word[1][cado_pkg::PERIOD_W-1:0];
    short_gain_reg   = word[2];
    long_gain_reg    = word[3];
  endtask

  // Sender pause: wait until every bar went out and every result came back.
  task automatic wait_for_drain();
    do @(posedge clk);
    while (bar_queue.size() != 0 || in_valid || due_results.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    price_bar_t                    directed[$];
    logic [cado_pkg::PERIOD_W-1:0] sp, lp;
    logic [cado_pkg::GAIN_W-1:0]   sg, lg;

    avg_val  = '{default: '0};
    seed_sum = '{default: '0};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed bars under the reset config: mid, close at high and at low,
    // flat bars at both extremes, inverted and out-of-range closes, flow
    // saturating both ways until the line pins, zero volume, and a restart.
    directed = '{
      '{1'b1, 32'd100,        32'd50,         32'd75,         32'd1000},
      '{1'b0, 32'd100,        32'd50,         32'd100,        32'hFFFF_FFFF},
      '{1'b0, 32'd100,        32'd50,         32'd50,         32'hFFFF_FFFF},
      '{1'b0, 32'd0,          32'd0,          32'd0,          32'd0},
      '{1'b0, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF},
      '{1'b0, 32'd10,         32'd100,        32'd20,         32'd500},
      '{1'b0, 32'd10,         32'd100,        32'd200,        32'd7},
      '{1'b0, 32'hFFFF_FFFF,  32'd0,          32'h7FFF_FFFF,  32'd12345},
      '{1'b0, 32'd2,          32'd1,          32'hFFFF_FFFF,  32'hFFFF_FFFF},
      '{1'b0, 32'd2,          32'd1,          32'hFFFF_FFFF,  32'hFFFF_FFFF},
      '{1'b0, 32'd2,          32'd1,          32'hFFFF_FFFF,  32'hFFFF_FFFF},
      '{1'b0, 32'hFFFF_FFFF,  32'hFFFF_FFFE,  32'd0,          32'hFFFF_FFFF},
      '{1'b0, 32'hFFFF_FFFF,  32'hFFFF_FFFE,  32'd0,          32'hFFFF_FFFF},
      '{1'b0, 32'hFFFF_FFFF,  32'hFFFF_FFFE,  32'd0,          32'hFFFF_FFFF},
      '{1'b0, 32'd1,          32'd0,          32'd1,          32'd1},
      '{1'b0, 32'd3000,       32'd1000,       32'd2500,       32'd0},
      '{1'b0, 32'd3000,       32'd1000,       32'd2500,       32'd800},
      '{1'b1, 32'd5000,       32'd4000,       32'd4200,       32'd300}
    };
    foreach (directed[i]) bar_queue.insert(bar_queue.size(), directed[i]);
    repeat (6) bar_queue.insert(bar_queue.size(), draw_bar());

    for (int phase = 1; phase <= RANDOM_PHASES; phase++) begin
      wait_for_drain();
      repeat (4) @(posedge clk);
      case (phase)
        1: begin  // shortest periods, gain of exactly one
          sp = 11'd1;    lp = 11'd1;    sg = 31'h4000_0000; lg = 31'h4000_0000;
        end
        2: begin  // zero periods act as one, zero gain freezes the averages
          sp = 11'd0;    lp = 11'd0;    sg = '0;            lg = '0;
        end
        3: begin  // long below short
          sp = 11'd6;    lp = 11'd2;
          sg = cado_pkg::GAIN_W'($urandom_range(0, 1 << 30));
          lg = cado_pkg::GAIN_W'($urandom_range(0, 1 << 30));
        end
        4: begin  // out-of-range short period, gain above one
          sp = 11'd2047; lp = 11'd40;   sg = 31'h7FFF_FFFF;
          lg = cado_pkg::GAIN_W'($urandom_range(0, 1 << 30));
        end
        5: begin  // largest long period, seeding never finishes here
          sp = 11'd6;    lp = 11'd1024;
          sg = cado_pkg::GAIN_W'($urandom_range(0, 1 << 30));
          lg = cado_pkg::GAIN_W'($urandom_range(0, 1 << 30));
        end
        6: begin  // long period drops below the bar count before seeding
          sp = 11'd2;    lp = 11'd3;    sg = 31'h7FFF_FFFF; lg = 31'h7FFF_FFFF;
        end
        7: begin
          sp = cado_pkg::PERIOD_W'($urandom_range(1, 16));
          lp = cado_pkg::PERIOD_W'($urandom_range(sp, 24));
          sg = cado_pkg::GAIN_W'($urandom_range(0, 1 << 30));
          lg = cado_pkg::GAIN_W'($urandom_range(0, 1 << 30));
        end
        default: begin
          sp = cado_pkg::PERIOD_W'($urandom_range(1, 8));
          lp = cado_pkg::PERIOD_W'($urandom_range(1, 12));
          sg = cado_pkg::GAIN_W'($urandom_range(0, 32'h7FFF_FFFF));
          lg = cado_pkg::GAIN_W'($urandom_range(0, 32'h7FFF_FFFF));
        end
      endcase
      program_regs(sp, lp, sg, lg);

      // Cycle through: no idling, sender idle, receiver stall, both.
      case ((phase - 1) % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 51; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 51; end
        default: begin send_idle_pct = 25; stall_pct = 25; end
      endcase

      // Pressure: block the receiver for a long stretch while bars keep
      // coming, so the output register fills and the input stalls.
      if (phase == 3) hold_req <= ~hold_req;

      repeat (BARS_PER_PHASE) bar_queue.insert(bar_queue.size(), draw_bar());
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && due_results.size() == 0)
      $display("chaikin_ad_oscillator_tb: done, clean");
    else
      $display("chaikin_ad_oscillator_tb: done, errors");
    $finish;
  end

endmodule

/* chaikin_ad_oscillator.f */
src/cado_pkg.sv
src/cado_div.sv
src/chaikin_ad_oscillator.sv
test/chaikin_ad_oscillator_tb.sv
